>>> rtl/positional_array_list_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional array list unit
// Implication checks sampled on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PAL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define PAL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Operation codes, sequencer states and fixed field widths of the list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

   // Fixed field widths
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 8;
   localparam int LEN_W    = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Operation carried by a request
   typedef enum logic [FUNC_W-1:0] {
      FUNC_GET    = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_LOCATE = 2'd3
   } func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_DEL_FIRST,
      ST_DEL_SHIFT,
      ST_LOC
   } state_type;

endpackage

`default_nettype wire

>>> rtl/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/positional_array_list_unit.sv
// Get reads; append writes; insert shifts the tail up, then writes; delete reads,
// then shifts any tail down; locate reads from the front to the first hit or end.
// Bad positions, full-list inserts and locate on an empty list answer with no RAM access.
// One request at a time; the dual-port element RAM moves one element per cycle.
// Reset clears state, count and response valid; the store is undefined until written,
// with no clearing pass, so requests are taken straight after reset.
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded ordered byte list with 1-based positions: get, insert, delete and
// locate, kept in one RAM and shifted one element per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_array_list_unit_defines.svh"

module positional_array_list_unit #(
   parameter int CAPACITY = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [pal_pkg::REQ_DATA_W-1:0]    req_tdata,  // position[6:0], value[14:7]
   input  wire logic [pal_pkg::FUNC_W-1:0]        req_tuser,  // func[1:0]
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [pal_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // data[7:0], found_position[14:8],
                                                              // list_length[21:15], is_empty[22]
   output logic                                   rsp_tuser   // ok[0]
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

   // Registers
   pal_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [pal_pkg::POS_W-1:0]   pos_ff;
   logic [pal_pkg::VALUE_W-1:0] val_ff;
   logic [pal_pkg::VALUE_W-1:0] hold_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_ok_ff;
   logic [pal_pkg::VALUE_W-1:0] rsp_data_ff;
   logic [pal_pkg::LEN_W-1:0]   rsp_found_ff;
   logic [pal_pkg::LEN_W-1:0]   rsp_len_ff;
   logic                        rsp_empty_ff;

   // Request fields
   pal_pkg::func_type           in_func;
   logic [pal_pkg::POS_W-1:0]   in_pos;
   logic [pal_pkg::VALUE_W-1:0] in_val;
   logic                        req_fire;

   // Wide working values
   logic [WW-1:0] in_pos_w, in_pos_m1, pos_w, pos_m1;
   logic [WW-1:0] cnt_w, cnt_m1, cnt_p1, cap_w;
   logic [WW-1:0] idx_w, idx_m1, idx_m2, idx_p1, idx_p2, count_in_w;
   logic          in_get_ok, in_ins_ok, in_append;
   logic          last_ins, last_del, pos_is_last, loc_hit, loc_end;

   // RAM port
   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   logic [pal_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

   // Response load
   logic                        rsp_load;
   logic                        ld_ok;
   logic [pal_pkg::VALUE_W-1:0] ld_data;
   logic [pal_pkg::LEN_W-1:0]   ld_found;

   // Unpack the request
   assign in_func  = pal_pkg::func_type'(req_tuser);
   assign in_pos   = req_tdata[pal_pkg::POS_W-1:0];
   assign in_val   = req_tdata[pal_pkg::POS_W +: pal_pkg::VALUE_W];
   assign req_tready = (state_ff == pal_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire = req_tvalid && req_tready;

   // Position and count arithmetic
   assign in_pos_w  = WW'(in_pos);
   assign in_pos_m1 = in_pos_w - WW'(1);
   assign pos_w     = WW'(pos_ff);
   assign pos_m1    = pos_w - WW'(1);
   assign cnt_w     = WW'(count_ff);
   assign cnt_m1    = cnt_w - WW'(1);
   assign cnt_p1    = cnt_w + WW'(1);
   assign cap_w     = WW'(CAPACITY);
   assign idx_w     = WW'(idx_ff);
   assign idx_m1    = idx_w - WW'(1);
   assign idx_m2    = idx_w - WW'(2);
   assign idx_p1    = idx_w + WW'(1);
   assign idx_p2    = idx_w + WW'(2);
   assign count_in_w = WW'(count_in);

   assign in_get_ok   = (in_pos_w != '0) && (in_pos_w <= cnt_w);
   assign in_ins_ok   = (in_pos_w != '0) && (in_pos_w <= cnt_p1) && (cnt_w < cap_w);
   assign in_append   = (in_pos_w == cnt_p1);
   assign last_ins    = (idx_w == pos_w);
   assign pos_is_last = (pos_w == cnt_w);
   assign last_del    = (idx_p2 == cnt_w);
   assign loc_hit     = (ram_rdata == val_ff);
   assign loc_end     = (idx_p1 == cnt_w);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pal_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (in_func)
                  pal_pkg::FUNC_GET: begin
                     state_in = in_get_ok ? pal_pkg::ST_GET : pal_pkg::ST_IDLE;
                  end
                  pal_pkg::FUNC_INSERT: begin
                     if (in_ins_ok) begin
                        state_in = in_append ? pal_pkg::ST_INS_PUT : pal_pkg::ST_INS_SHIFT;
                     end
                  end
                  pal_pkg::FUNC_DELETE: begin
                     state_in = in_get_ok ? pal_pkg::ST_DEL_FIRST : pal_pkg::ST_IDLE;
                  end
                  default: begin
                     state_in = (count_ff != '0) ? pal_pkg::ST_LOC : pal_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         pal_pkg::ST_GET: begin
            state_in = pal_pkg::ST_IDLE;
         end
         pal_pkg::ST_INS_SHIFT: begin
            if (last_ins) begin
               state_in = pal_pkg::ST_INS_PUT;
            end
         end
         pal_pkg::ST_INS_PUT: begin
            state_in = pal_pkg::ST_IDLE;
         end
         pal_pkg::ST_DEL_FIRST: begin
            state_in = pos_is_last ? pal_pkg::ST_IDLE : pal_pkg::ST_DEL_SHIFT;
         end
         pal_pkg::ST_DEL_SHIFT: begin
            if (last_del) begin
               state_in = pal_pkg::ST_IDLE;
            end
         end
         pal_pkg::ST_LOC: begin
            if (loc_hit || loc_end) begin
               state_in = pal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::ST_IDLE;
         end
      endcase
   end

   // RAM accesses, walk index, count and response load
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = '0;
      idx_in    = idx_ff;
      count_in  = count_ff;
      rsp_load  = 1'b0;
      ld_ok     = 1'b0;
      ld_data   = '0;
      ld_found  = '0;
      case (state_ff)
         pal_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (in_func)
                  pal_pkg::FUNC_GET: begin
                     if (in_get_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = in_pos_m1[AW-1:0];
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  pal_pkg::FUNC_INSERT: begin
                     if (in_ins_ok) begin
                        idx_in = count_ff;
                        if (!in_append) begin
                           ram_re    = 1'b1;
                           ram_raddr = cnt_m1[AW-1:0];
                        end
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  pal_pkg::FUNC_DELETE: begin
                     if (in_get_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = in_pos_m1[AW-1:0];
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     if (count_ff != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        idx_in    = '0;
                     end else begin
                        rsp_load = 1'b1;
                        ld_ok    = 1'b1;
                     end
                  end
               endcase
            end
         end
         pal_pkg::ST_GET: begin
            rsp_load = 1'b1;
            ld_ok    = 1'b1;
            ld_data  = ram_rdata;
         end
         pal_pkg::ST_INS_SHIFT: begin
            // move the element below up by one, fetch the next one down
            ram_we = 1'b1;
            if (!last_ins) begin
               ram_re    = 1'b1;
               ram_raddr = idx_m2[AW-1:0];
               idx_in    = idx_m1[CW-1:0];
            end
         end
         pal_pkg::ST_INS_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_m1[AW-1:0];
            ram_wdata = val_ff;
            count_in  = cnt_p1[CW-1:0];
            rsp_load  = 1'b1;
            ld_ok     = 1'b1;
         end
         pal_pkg::ST_DEL_FIRST: begin
            if (pos_is_last) begin
               count_in = cnt_m1[CW-1:0];
               rsp_load = 1'b1;
               ld_ok    = 1'b1;
               ld_data  = ram_rdata;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = pos_w[AW-1:0];
               idx_in    = pos_m1[CW-1:0];
            end
         end
         pal_pkg::ST_DEL_SHIFT: begin
            // move the element above down by one, fetch the next one up
            ram_we = 1'b1;
            if (last_del) begin
               count_in = cnt_m1[CW-1:0];
               rsp_load = 1'b1;
               ld_ok    = 1'b1;
               ld_data  = hold_ff;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_p2[AW-1:0];
               idx_in    = idx_p1[CW-1:0];
            end
         end
         pal_pkg::ST_LOC: begin
            if (loc_hit) begin
               rsp_load = 1'b1;
               ld_ok    = 1'b1;
               ld_found = idx_p1[pal_pkg::LEN_W-1:0];
            end else if (loc_end) begin
               rsp_load = 1'b1;
               ld_ok    = 1'b1;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_p1[AW-1:0];
               idx_in    = idx_p1[CW-1:0];
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Element store
   pal_ram #(
      .WIDTH (pal_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pal_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: hold request fields, walk index, removed byte and response
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_fire) begin
         pos_ff <= in_pos;
         val_ff <= in_val;
      end
      if (state_ff == pal_pkg::ST_DEL_FIRST) begin
         hold_ff <= ram_rdata;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= ld_ok;
         rsp_data_ff  <= ld_data;
         rsp_found_ff <= ld_found;
         rsp_len_ff   <= count_in_w[pal_pkg::LEN_W-1:0];
         rsp_empty_ff <= (count_in == '0);
      end
   end

   // Pack the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {1'b0, rsp_empty_ff, rsp_len_ff, rsp_found_ff, rsp_data_ff};

   // Checks
   `PAL_ASSERT_IMP(a_count_bound, 1'b1, cnt_w <= cap_w, "element count above capacity")
   `PAL_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
                   "read and write of the same entry in one cycle")
   `PAL_ASSERT_NXT(a_count_hold, !rsp_load, $stable(count_ff),
                   "element count changed without a response")
   `PAL_ASSERT_IMP(a_del_inside, state_ff == pal_pkg::ST_DEL_SHIFT, idx_p2 <= cnt_w,
                   "delete shift walked past the list end")

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Positional array list unit testbench
// Drives get, insert, delete and locate requests over the request stream,
// predicts every response from a private copy of the list and compares each
// accepted response field by field, under several patterns of sender idling
// and receiver back-pressure, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int LIST_CAPACITY = 64;
   localparam int RANDOM_ITEMS  = 450;   // per idling phase
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_CYCLES   = 300;

   // Expected response, one per request
   typedef struct packed {
      logic                          ok;
      logic [pal_pkg::VALUE_W-1:0]   data;
      logic [pal_pkg::POS_W-1:0]     found;
      logic [pal_pkg::LEN_W-1:0]     length;
      logic                          empty;
   } list_result_type;

   // Direction the random stream pushes the list length
   typedef enum int {
      MODE_GROW,
      MODE_SHRINK,
      MODE_MIXED
   } fill_mode_type;

   // Scoreboard: private list copy and the queue of awaited responses
   class list_scoreboard;
      logic [pal_pkg::VALUE_W-1:0] elements [LIST_CAPACITY];
      int unsigned                 length;
      list_result_type             awaited [$];
      int unsigned                 mismatches;

      function new();
         length     = 0;
         mismatches = 0;
      endfunction

      // Apply one accepted request to the list copy and queue its response
      function void note_request(pal_pkg::func_type f, int unsigned pos,
                                 logic [pal_pkg::VALUE_W-1:0] val);
         list_result_type res;
         res = '0;
         case (f)
            pal_pkg::FUNC_GET: begin
               if (pos >= 1 && pos <= length) begin
                  res.data = elements[pos-1];
                  res.ok   = 1'b1;
               end
            end
            pal_pkg::FUNC_INSERT: begin
               if (pos >= 1 && pos <= length + 1 && length < LIST_CAPACITY) begin
                  for (int k = length; k > pos - 1; k--)
                     elements[k] = elements[k-1];
                  elements[pos-1] = val;
                  length++;
                  res.ok = 1'b1;
               end
            end
            pal_pkg::FUNC_DELETE: begin
               if (pos >= 1 && pos <= length) begin
                  res.data = elements[pos-1];
                  for (int k = pos - 1; k + 1 < length; k++)
                     elements[k] = elements[k+1];
                  length--;
                  res.ok = 1'b1;
               end
            end
            default: begin
               res.ok = 1'b1;
               for (int k = 0; k < length; k++) begin
                  if (elements[k] == val && res.found == 0)
                     res.found = pal_pkg::POS_W'(k + 1);
               end
            end
         endcase
         res.length = pal_pkg::LEN_W'(length);
         res.empty  = (length == 0);
         awaited.push_back(res);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      // Compare one accepted response with the oldest expectation
      task check_response(logic ok, logic [pal_pkg::RSP_DATA_W-1:0] word);
         list_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("response with none awaited, ok=%0b tdata=%h", ok, word));
            return;
         end
         want = awaited.pop_front();
         if (ok !== want.ok)
            report($sformatf("ok %0b, expected %0b", ok, want.ok));
         if (word[7:0] !== want.data)
            report($sformatf("data %h, expected %h", word[7:0], want.data));
         if (word[14:8] !== want.found)
            report($sformatf("found_position %0d, expected %0d", word[14:8], want.found));
         if (word[21:15] !== want.length)
            report($sformatf("list_length %0d, expected %0d", word[21:15], want.length));
         if (word[22] !== want.empty)
            report($sformatf("is_empty %0b, expected %0b", word[22], want.empty));
      endtask
   endclass

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pal_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;   // position[6:0], value[14:7]
   logic [pal_pkg::FUNC_W-1:0]       req_tuser  = '0;   // func[1:0]
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pal_pkg::RSP_DATA_W-1:0]   rsp_tdata;         // data[7:0], found_position[14:8],
                                                        // list_length[21:15], is_empty[22]
   logic                             rsp_tuser;         // ok[0]

   list_scoreboard sb = new();

   int unsigned    idle_pct     = 0;
   int unsigned    stall_pct    = 0;
   logic           hold_rsp     = 1'b0;
   logic           pressure_go  = 1'b0;
   fill_mode_type  fill_mode    = MODE_GROW;

   positional_array_list_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one request after a random gap; return at the edge that accepts it
   task send_request(pal_pkg::func_type f, int unsigned pos, int unsigned val);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {1'b0, 8'(val), 7'(pos)};
      do @(posedge clock); while (!req_tready);
      sb.note_request(f, pos, 8'(val));
   endtask

   // Pick a position: mostly in range, some zero, just past the end, or anywhere (any for locate)
   function automatic int unsigned pick_position(pal_pkg::func_type f);
      int unsigned top;
      int unsigned r;
      top = (f == pal_pkg::FUNC_INSERT) ? sb.length + 1 : sb.length;
      r   = $urandom_range(99);
      if (f == pal_pkg::FUNC_LOCATE)
         return $urandom_range(65);
      if (r < 80 && top >= 1)
         return $urandom_range(top, 1);
      if (r < 88)
         return 0;
      if (r < 95)
         return top + 1;
      return $urandom_range(65);
   endfunction

   // Pick a value, often one already held so that locate hits
   function automatic int unsigned pick_value(pal_pkg::func_type f);
      int unsigned share;
      share = (f == pal_pkg::FUNC_LOCATE) ? 70 : 20;
      if (sb.length > 0 && $urandom_range(99) < share)
         return sb.elements[$urandom_range(sb.length - 1)];
      return $urandom_range(255);
   endfunction

   // Random request, weighted by the current fill mode
   task random_request();
      int unsigned       r;
      pal_pkg::func_type f;
      // steer the length between empty and full, lingering at the ends
      if (sb.length == LIST_CAPACITY && fill_mode == MODE_GROW && $urandom_range(3) == 0)
         fill_mode = MODE_SHRINK;
      else if (sb.length == 0 && fill_mode == MODE_SHRINK && $urandom_range(3) == 0)
         fill_mode = MODE_GROW;
      else if ($urandom_range(99) < 2)
         fill_mode = fill_mode_type'($urandom_range(2));
      r = $urandom_range(99);
      case (fill_mode)
         MODE_GROW:   f = (r < 55) ? pal_pkg::FUNC_INSERT : (r < 70) ? pal_pkg::FUNC_GET :
                          (r < 80) ? pal_pkg::FUNC_DELETE : pal_pkg::FUNC_LOCATE;
         MODE_SHRINK: f = (r < 55) ? pal_pkg::FUNC_DELETE : (r < 65) ? pal_pkg::FUNC_INSERT :
                          (r < 80) ? pal_pkg::FUNC_GET : pal_pkg::FUNC_LOCATE;
         default:     f = pal_pkg::func_type'(r % 4);
      endcase
      send_request(f, pick_position(f), pick_value(f));
   endtask

   // Receiver: check accepted responses and drive ready with random stalls
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata);
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long receiver hold-off so the block backs up onto its input
   initial begin
      wait (pressure_go);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Stimulus and end of run
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list: every access is out of range, locate misses
      send_request(pal_pkg::FUNC_GET,    1, 8'h00);
      send_request(pal_pkg::FUNC_DELETE, 1, 8'h00);
      send_request(pal_pkg::FUNC_LOCATE, 0, 8'h00);
      send_request(pal_pkg::FUNC_INSERT, 0, 8'h01);
      send_request(pal_pkg::FUNC_INSERT, 2, 8'h02);
      // build a short list through append, front and middle inserts
      send_request(pal_pkg::FUNC_INSERT, 1, 8'h00);
      send_request(pal_pkg::FUNC_INSERT, 2, 8'hFF);
      send_request(pal_pkg::FUNC_INSERT, 1, 8'hA5);
      send_request(pal_pkg::FUNC_INSERT, 3, 8'h5A);
      send_request(pal_pkg::FUNC_INSERT, 2, 8'hFF);
      // reads at and around the bounds
      send_request(pal_pkg::FUNC_GET,    0, 8'h00);
      send_request(pal_pkg::FUNC_GET,    1, 8'h00);
      send_request(pal_pkg::FUNC_GET,    5, 8'hFF);
      send_request(pal_pkg::FUNC_GET,    6, 8'h00);
      send_request(pal_pkg::FUNC_GET,   65, 8'hFF);
      // locate: first of two matches, absent, and with a stray position
      send_request(pal_pkg::FUNC_LOCATE, 0, 8'hFF);
      send_request(pal_pkg::FUNC_LOCATE, 65, 8'h77);
      send_request(pal_pkg::FUNC_LOCATE, 64, 8'h00);
      // removal at both ends and in the middle, plus bad positions
      send_request(pal_pkg::FUNC_DELETE, 6, 8'h00);
      send_request(pal_pkg::FUNC_DELETE, 5, 8'h00);
      send_request(pal_pkg::FUNC_DELETE, 1, 8'h00);
      send_request(pal_pkg::FUNC_DELETE, 2, 8'h00);
      send_request(pal_pkg::FUNC_DELETE, 0, 8'h00);

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 66 : (phase == 3) ? 31 : 0;
         stall_pct = (phase == 2) ? 66 : (phase == 3) ? 31 : 0;
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase == 0 && n == 50)
               pressure_go <= 1'b1;
            random_request();
         end
      end
      req_tvalid <= 1'b0;

      // drain outstanding responses, then let the block settle
      while (sb.awaited.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: end the run if the block stops answering
   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/pal_pkg.sv
rtl/pal_ram.sv
rtl/positional_array_list_unit.sv
tb/tb.sv
